// ----- design/wlkv_pkg.sv -----
`timescale 1ns / 1ps

package wlkv_pkg;

   // Fixed widths of the request and response fields
   localparam int REQ_TYPE_W   = 2;
   localparam int KEY_W_PORT   = 32;
   localparam int VALUE_W_PORT = 32;
   localparam int STATUS_W     = 2;
   localparam int SLOT_W       = 4;
   localparam int SEQ_RES_W    = 16;
   localparam int BLOCK_W      = 8;

   // Internal bookkeeping widths
   localparam int SEQ_W        = 17;   // signed write sequence
   localparam int LIMIT_W      = 16;
   localparam int COUNT_W      = 9;
   localparam int LIVE_MAX_W   = 9;    // holds up to 256 live entries

   // Configuration port
   localparam int CSR_DATA_W   = 16;

   typedef enum logic [0:0] {
      CSR_WRITE_LIMIT = 1'b0,
      CSR_BLOCK_COUNT = 1'b1
   } csr_idx_type;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // Commands from the scan controller to the wear bookkeeping
   typedef struct packed {
      logic check;     // add or delete accepted: test for a block move
      logic bump;      // successful add or delete: take a sequence number
      logic live_up;   // new slot filled
      logic live_down; // slot freed
   } wear_cmd_type;

   typedef struct packed {
      logic                  moved;
      logic [BLOCK_W-1:0]    block;
      logic [SEQ_RES_W-1:0]  seq_next;
      logic [LIVE_MAX_W-1:0] live;
   } wear_stat_type;

endpackage

// ----- design/wlkv_if.sv -----
`timescale 1ns / 1ps

interface wlkv_req_if;
   logic                                valid;
   logic                                ready;
   logic [wlkv_pkg::REQ_TYPE_W-1:0]     req_type;
   logic [wlkv_pkg::KEY_W_PORT-1:0]     key;
   logic [wlkv_pkg::VALUE_W_PORT-1:0]   value;

   modport source (output valid, output req_type, output key, output value, input ready);
   modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface wlkv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [wlkv_pkg::STATUS_W-1:0]       status;
   logic [wlkv_pkg::VALUE_W_PORT-1:0]   read_value;
   logic [wlkv_pkg::SLOT_W-1:0]         slot;
   logic [wlkv_pkg::SEQ_RES_W-1:0]      sequence_res;
   logic [wlkv_pkg::BLOCK_W-1:0]        block_index;
   logic                                block_moved;

   modport source (output valid, output status, output read_value, output slot,
                   output sequence_res, output block_index, output block_moved,
                   input ready);
   modport sink   (input valid, input status, input read_value, input slot,
                   input sequence_res, input block_index, input block_moved,
                   output ready);
endinterface

// ----- design/wlkv_store.sv -----
`timescale 1ns / 1ps

module wlkv_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/wlkv_wear.sv -----
`timescale 1ns / 1ps

module wlkv_wear #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  wlkv_pkg::csr_idx_type               csr_index,
   input  logic [wlkv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wlkv_pkg::wear_cmd_type              cmd,
   output wlkv_pkg::wear_stat_type             stat
);
   import wlkv_pkg::*;

   localparam int LIVE_W = $clog2(ENTRIES + 1);

   logic [LIMIT_W-1:0]     limit_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic signed [SEQ_W-1:0] seq_ff, seq_in;
   logic [LIVE_W-1:0]      live_ff, live_in;
   logic [BLOCK_W-1:0]     block_ff, block_in;
   logic                   moved_ff, moved_in;

   logic signed [SEQ_W:0]  limit_m1;
   logic signed [SEQ_W:0]  seq_ext;
   logic                   move_due;
   logic                   blk_wrap;

   assign limit_m1 = $signed({2'b00, limit_ff}) - 18'sd1;
   assign seq_ext  = {seq_ff[SEQ_W-1], seq_ff};
   assign move_due = seq_ext >= limit_m1;
   assign blk_wrap = ({2'b00, block_ff} + 10'd1) >= {1'b0, count_ff};

   always_comb begin
      seq_in   = seq_ff;
      live_in  = live_ff;
      block_in = block_ff;
      moved_in = moved_ff;
      if (cmd.check) begin
         moved_in = move_due;
         if (move_due) begin
            block_in = blk_wrap ? '0 : BLOCK_W'({2'b00, block_ff} + 10'd1);
            seq_in   = $signed(SEQ_W'(live_ff)) - 17'sd1;
         end
      end
      if (cmd.bump) begin
         seq_in = seq_ff + 17'sd1;
      end
      if (cmd.live_up) begin
         live_in = live_ff + LIVE_W'(1);
      end else if (cmd.live_down) begin
         live_in = live_ff - LIVE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= -17'sd1;
         live_ff  <= '0;
         block_ff <= '0;
         moved_ff <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         live_ff  <= live_in;
         block_ff <= block_in;
         moved_ff <= moved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'd1024;
         count_ff <= 9'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WRITE_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_BLOCK_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
         endcase
      end
   end

   assign stat.moved    = moved_ff;
   assign stat.block    = block_ff;
   assign stat.seq_next = SEQ_RES_W'(seq_ff + 17'sd1);
   assign stat.live     = LIVE_MAX_W'(live_ff);

endmodule

// ----- design/wear_levelled_key_value_table_core.sv -----
`timescale 1ns / 1ps
// A request beat is taken only in the idle state. The block then reads every slot in turn
//   through the single read port, compares each one in the compare stage, and in the
//   finishing step writes back and loads the response register; that step waits while the
//   register still holds an untaken beat. A new request beat is taken only once it is idle again.
// Reset (synchronous, active high): all slots empty, sequence at minus one, block zero,
//   write limit 1024, block count 8. The memory itself needs no clearing.
module wear_levelled_key_value_table_core #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   wlkv_req_if.sink                         req_bus,
   wlkv_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  wlkv_pkg::csr_idx_type            csr_index,
   input  logic [wlkv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wlkv_pkg::*;

   // Keys and values wider than the ports only ever hold zero in the upper bits,
   // so store just what the ports can carry.
   localparam int KEY_W  = (KEY_BITS < KEY_W_PORT) ? KEY_BITS : KEY_W_PORT;
   localparam int VAL_W  = (VALUE_BITS < VALUE_W_PORT) ? VALUE_BITS : VALUE_W_PORT;
   localparam int IDX_W  = $clog2((ENTRIES > 1) ? ENTRIES : 2);
   localparam int DATA_W = KEY_W + VAL_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type               state_ff, state_in;

   // Request held for the whole scan
   op_type                  op_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [VAL_W-1:0]        val_ff;

   // Read issue and compare stages of the scan
   logic                    rd_on_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    cmp_vld_ff;
   logic [IDX_W-1:0]        cmp_idx_ff;

   // Scan results
   logic                    hit_ff;
   logic [IDX_W-1:0]        hit_idx_ff;
   logic [VAL_W-1:0]        hit_val_ff;
   logic                    empty_ff;
   logic [IDX_W-1:0]        empty_idx_ff;

   // Slot occupancy lives in flops so that reset empties the table at once
   logic [ENTRIES-1:0]      valid_ff;

   // Response register
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [VALUE_W_PORT-1:0] rsp_value_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [SEQ_RES_W-1:0]    rsp_seq_ff;
   logic [BLOCK_W-1:0]      rsp_block_ff;
   logic                    rsp_moved_ff;

   logic                    req_fire;
   logic                    rd_issue;
   logic                    scan_last;
   logic                    finish;
   logic                    cmp_match;
   logic                    is_write;

   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [DATA_W-1:0]       mem_rdata;
   logic [KEY_W-1:0]        rd_key;
   logic [VAL_W-1:0]        rd_val;

   wear_cmd_type            wear_cmd;
   wear_stat_type           wear_stat;

   // Result of the finishing step
   status_type              fin_status;
   logic [IDX_W-1:0]        fin_slot;
   logic                    fin_slot_en;
   logic                    fin_read_en;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rd_issue      = (state_ff == S_SCAN) && rd_on_ff;
   assign scan_last     = cmp_vld_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1));
   // Finish only once the response register is free or being emptied
   assign finish        = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign is_write      = (op_ff == OP_ADD) || (op_ff == OP_DELETE);

   assign rd_key    = mem_rdata[DATA_W-1:VAL_W];
   assign rd_val    = mem_rdata[VAL_W-1:0];
   assign cmp_match = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_key == key_ff);

   // State sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_SCAN;
         S_SCAN:  if (scan_last) state_in = S_DONE;
         S_DONE:  if (finish) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= op_type'(req_bus.req_type);
         key_ff <= req_bus.key[KEY_W-1:0];
         val_ff <= req_bus.value[VAL_W-1:0];
      end
   end

   // Read issue: walk every slot once, compare each slot in the cycle after its read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_on_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= rd_issue;
         if (req_fire) begin
            rd_on_ff <= 1'b1;
         end else if (rd_issue && (rd_idx_ff == IDX_W'(ENTRIES - 1))) begin
            rd_on_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_idx_ff <= '0;
      end else if (rd_issue) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
      cmp_idx_ff <= rd_idx_ff;
   end

   // Keep the first match and the lowest empty slot
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else if (req_fire) begin
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else if (cmp_vld_ff) begin
         if (cmp_match && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!valid_ff[cmp_idx_ff] && !empty_ff) begin
            empty_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_match && !hit_ff) begin
         hit_idx_ff <= cmp_idx_ff;
         hit_val_ff <= rd_val;
      end
      if (cmp_vld_ff && !valid_ff[cmp_idx_ff] && !empty_ff) begin
         empty_idx_ff <= cmp_idx_ff;
      end
   end

   // Finishing step: decide the outcome, then write back
   always_comb begin
      fin_status  = ST_MISS;
      fin_slot    = '0;
      fin_slot_en = 1'b0;
      fin_read_en = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = hit_idx_ff;
      wear_cmd    = '0;
      wear_cmd.check = req_fire && ((op_type'(req_bus.req_type) == OP_ADD) ||
                                    (op_type'(req_bus.req_type) == OP_DELETE));
      case (op_ff)
         OP_ADD: begin
            if (hit_ff) begin
               fin_status  = ST_OK;
               fin_slot    = hit_idx_ff;
               fin_slot_en = 1'b1;
               mem_we      = finish;
               wear_cmd.bump = finish;
            end else if (empty_ff) begin
               fin_status  = ST_OK;
               fin_slot    = empty_idx_ff;
               fin_slot_en = 1'b1;
               mem_we      = finish;
               mem_waddr   = empty_idx_ff;
               wear_cmd.bump    = finish;
               wear_cmd.live_up = finish;
            end else begin
               fin_status = ST_FULL;
            end
         end
         OP_DELETE: begin
            if (hit_ff) begin
               fin_status  = ST_OK;
               fin_slot    = hit_idx_ff;
               fin_slot_en = 1'b1;
               wear_cmd.bump      = finish;
               wear_cmd.live_down = finish;
            end
         end
         OP_FIND: begin
            if (hit_ff) begin
               fin_status  = ST_OK;
               fin_slot    = hit_idx_ff;
               fin_slot_en = 1'b1;
               fin_read_en = 1'b1;
            end
         end
         default: begin
            fin_status = ST_MISS;
         end
      endcase
   end

   // Slot occupancy: set on a new add, clear on a delete hit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (finish && fin_slot_en) begin
         if (op_ff == OP_ADD) begin
            valid_ff[fin_slot] <= 1'b1;
         end else if (op_ff == OP_DELETE) begin
            valid_ff[fin_slot] <= 1'b0;
         end
      end
   end

   // Response register: load on finish, drop when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= fin_status;
         rsp_value_ff  <= fin_read_en ? VALUE_W_PORT'(hit_val_ff) : '0;
         rsp_slot_ff   <= fin_slot_en ? SLOT_W'(fin_slot) : '0;
         rsp_seq_ff    <= (is_write && fin_slot_en) ? wear_stat.seq_next : '0;
         rsp_block_ff  <= wear_stat.block;
         rsp_moved_ff  <= is_write && wear_stat.moved;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.read_value   = rsp_value_ff;
   assign rsp_bus.slot         = rsp_slot_ff;
   assign rsp_bus.sequence_res = rsp_seq_ff;
   assign rsp_bus.block_index  = rsp_block_ff;
   assign rsp_bus.block_moved  = rsp_moved_ff;

   wlkv_store #(
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data ({key_ff, val_ff}),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff),
      .rd_data (mem_rdata)
   );

   wlkv_wear #(
      .ENTRIES (ENTRIES)
   ) u_wear (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (wear_cmd),
      .stat      (wear_stat)
   );

   // Live count tracks the occupancy flops
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(wear_stat.live))
      else $error("live entry count out of step with slot occupancy");

   // A taken request always starts a scan
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_SCAN) && rd_on_ff)
      else $error("request taken without starting a scan");

   // Memory writes only come from the finishing step
   a_write_done: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_DONE) && finish)
      else $error("memory written outside the finishing step");

   // A full report means every slot is occupied
   a_full_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (valid_ff == '1))
      else $error("table full reported with an empty slot");

   // A new response beat only follows a finishing step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised without a finished request");

endmodule

// ----- tb/sv/tb_wear_levelled_key_value_table_core.sv -----
`timescale 1ns / 1ps

module tb_wear_levelled_key_value_table_core;
   import wlkv_pkg::*;

   localparam int SLOTS            = 16;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int DRAIN_CYCLES     = 40;     // idle time after the last owed beat
   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 225;
   localparam int KEY_POOL         = 20;     // more keys than slots, so the table fills
   localparam int LONG_HOLD_AT     = 500;
   localparam int LONG_HOLD_CYCLES = 300;

   // One response beat, field for field
   typedef struct packed {
      status_type   status;
      logic [31:0]  read_value;
      logic [3:0]   slot;
      logic [15:0]  seq;
      logic [7:0]   block;
      logic         moved;
   } kv_result_t;

   // One row of the directed plan: either a request or a register update
   typedef struct {
      bit          is_csr;
      int          set_limit;   // -1 leaves the register alone
      int          set_count;
      op_type      op;
      logic [31:0] key;
      logic [31:0] value;
      bit          typed;       // want holds a hand-written result
      kv_result_t  want;
   } stim_row_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wlkv_req_if req_ch ();
   wlkv_rsp_if rsp_ch ();

   wear_levelled_key_value_table_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Table shadow: slots, wear bookkeeping and the two registers
   // ------------------------------------------------------------------
   bit          slot_used [SLOTS];
   logic [31:0] table_key [SLOTS];
   logic [31:0] table_val [SLOTS];
   int          wear_seq;
   int          live_count;
   logic [7:0]  active_block;
   int          limit_cfg;
   int          count_cfg;

   kv_result_t  expected_q [$];   // responses still owed by the block, oldest first

   int errors;
   int cycle_count;
   int beats_seen;
   int send_idle_pct;
   int sink_idle_pct;
   int n_items, n_add, n_del, n_find, n_moves, n_full, n_settings;

   function automatic int find_key(logic [31:0] k);
      int i;
      for (i = 0; i < SLOTS; i++)
         if (slot_used[i] && table_key[i] == k)
            return i;
      return -1;
   endfunction

   // Apply one request to the shadow table and return the beat it must produce
   function automatic kv_result_t predict_outcome(op_type op, logic [31:0] k, logic [31:0] v);
      kv_result_t r;
      int         hit;
      int         i;
      r = '0;
      r.status = ST_MISS;
      if (op == OP_ADD || op == OP_DELETE) begin
         // Decide the block move before the table is looked at
         if (wear_seq >= limit_cfg - 1) begin
            if (int'(active_block) >= count_cfg - 1)
               active_block = '0;
            else
               active_block = active_block + 8'd1;
            wear_seq = live_count - 1;
            r.moved  = 1'b1;
            n_moves++;
         end
         hit = find_key(k);
         if (op == OP_ADD) begin
            n_add++;
            if (hit < 0) begin
               // take the lowest empty slot
               for (i = 0; i < SLOTS; i++)
                  if (hit < 0 && !slot_used[i])
                     hit = i;
               if (hit >= 0) begin
                  slot_used[hit] = 1'b1;
                  table_key[hit] = k;
                  live_count++;
               end
            end
            if (hit >= 0) begin
               table_val[hit] = v;
               wear_seq++;
               r.status = ST_OK;
               r.slot   = 4'(hit);
               r.seq    = 16'(wear_seq);
            end else begin
               r.status = ST_FULL;
               n_full++;
            end
         end else begin
            n_del++;
            if (hit >= 0) begin
               slot_used[hit] = 1'b0;
               live_count--;
               wear_seq++;
               r.status = ST_OK;
               r.slot   = 4'(hit);
               r.seq    = 16'(wear_seq);
            end
         end
      end else if (op == OP_FIND) begin
         n_find++;
         hit = find_key(k);
         if (hit >= 0) begin
            r.status     = ST_OK;
            r.read_value = table_val[hit];
            r.slot       = 4'(hit);
         end
      end
      r.block = active_block;
      return r;
   endfunction

   function automatic kv_result_t outcome(status_type st, logic [31:0] rd, int at_slot,
                                          int seq_no, int blk, bit moved);
      kv_result_t r;
      r.status     = st;
      r.read_value = rd;
      r.slot       = 4'(at_slot);
      r.seq        = 16'(seq_no);
      r.block      = 8'(blk);
      r.moved      = moved;
      return r;
   endfunction

   function automatic stim_row_t item_row(op_type op, logic [31:0] k, logic [31:0] v);
      stim_row_t row;
      row.is_csr    = 1'b0;
      row.set_limit = -1;
      row.set_count = -1;
      row.op        = op;
      row.key       = k;
      row.value     = v;
      row.typed     = 1'b0;
      row.want      = '0;
      return row;
   endfunction

   function automatic stim_row_t typed_row(op_type op, logic [31:0] k, logic [31:0] v,
                                           kv_result_t want);
      stim_row_t row;
      row       = item_row(op, k, v);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic stim_row_t csr_row(int limit, int count);
      stim_row_t row;
      row           = item_row(OP_NONE, '0, '0);
      row.is_csr    = 1'b1;
      row.set_limit = limit;
      row.set_count = count;
      return row;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(9) < 8)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one beat and hold it until taken. Leave valid high when no gap
   // follows, so back-to-back beats never lower and raise it in one step.
   task automatic send_item(op_type op, logic [31:0] k, logic [31:0] v, bit typed,
                            kv_result_t want);
      kv_result_t r;
      int         gap;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= op;
      req_ch.key      <= k;
      req_ch.value    <= v;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      // beat taken at this edge: advance the shadow table
      r = predict_outcome(op, k, v);
      expected_q.push_back(typed ? want : r);
      n_items++;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = pick_gap();
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write registers only once every owed beat has come back.
   // A negative argument leaves that register untouched.
   task automatic apply_settings(int limit, int count);
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      if (limit >= 0) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_WRITE_LIMIT;
         csr_wdata <= CSR_DATA_W'(limit);
         @(posedge clock);
         limit_cfg = limit & 32'hFFFF;
      end
      if (count >= 0) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_BLOCK_COUNT;
         csr_wdata <= CSR_DATA_W'(count);
         @(posedge clock);
         count_cfg = count & 32'h1FF;
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // ------------------------------------------------------------------
   // Response side: check each beat, then choose ready for the next edge
   // ------------------------------------------------------------------
   initial begin : response_side
      kv_result_t exp_r;
      int         hold_left;
      bit         long_hold_done;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_ch.ready  <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
               beats_seen++;
               if (expected_q.size() == 0) begin
                  errors++;
                  $display("%0t: response beat arrived with nothing outstanding", $time);
               end else begin
                  exp_r = expected_q.pop_front();
                  check_field("status", 32'(exp_r.status), 32'(rsp_ch.status));
                  check_field("read_value", exp_r.read_value, rsp_ch.read_value);
                  check_field("slot", 32'(exp_r.slot), 32'(rsp_ch.slot));
                  check_field("sequence_res", 32'(exp_r.seq), 32'(rsp_ch.sequence_res));
                  check_field("block_index", 32'(exp_r.block), 32'(rsp_ch.block_index));
                  check_field("block_moved", 32'(exp_r.moved), 32'(rsp_ch.block_moved));
               end
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_ch.ready <= 1'b0;
            end else if (!long_hold_done && beats_seen >= LONG_HOLD_AT) begin
               // hold off long enough for the block to back up into its input
               long_hold_done = 1'b1;
               hold_left      = LONG_HOLD_CYCLES;
               rsp_ch.ready  <= 1'b0;
            end else if ($urandom_range(99) < sink_idle_pct) begin
               hold_left     = pick_gap() - 1;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: end a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d beats outstanding",
                  cycle_count, expected_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus: directed plan, then randomized phases
   // ------------------------------------------------------------------
   initial begin : stimulus
      stim_row_t   plan [$];
      logic [31:0] key_pool [KEY_POOL];
      int          phase_limit [PHASES];
      int          phase_count [PHASES];
      int          phase_send_idle [PHASES];
      int          phase_sink_idle [PHASES];
      int          i, ph, n, pick;
      op_type      op;
      logic [31:0] k;

      phase_limit     = '{1, 3, 0, 16, 65535, 2, 7, 1024};
      phase_count     = '{1, 2, 511, 4, 256, 0, 300, 8};
      phase_send_idle = '{0, 20, 50, 10, 0, 35, 60, 15};
      phase_sink_idle = '{0, 40, 10, 25, 0, 60, 15, 30};

      // drive every input to a known value before the first edge
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_WRITE_LIMIT;
      csr_wdata       <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= OP_NONE;
      req_ch.key      <= '0;
      req_ch.value    <= '0;

      for (i = 0; i < SLOTS; i++) begin
         slot_used[i] = 1'b0;
         table_key[i] = '0;
         table_val[i] = '0;
      end
      wear_seq      = -1;
      live_count    = 0;
      active_block  = '0;
      limit_cfg     = 1024;
      count_cfg     = 8;
      send_idle_pct = 20;
      sink_idle_pct = 20;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Hand-written results: empty table after reset, extreme keys and
      // values, update in place, delete, refill of the lowest free slot
      plan.push_back(typed_row(OP_FIND, 32'h0, 32'h0, outcome(ST_MISS, 0, 0, 0, 0, 0)));
      plan.push_back(typed_row(OP_DELETE, 32'hFFFF_FFFF, 32'h0,
                               outcome(ST_MISS, 0, 0, 0, 0, 0)));
      plan.push_back(typed_row(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               outcome(ST_MISS, 0, 0, 0, 0, 0)));
      plan.push_back(typed_row(OP_ADD, 32'h0, 32'hFFFF_FFFF, outcome(ST_OK, 0, 0, 0, 0, 0)));
      plan.push_back(typed_row(OP_ADD, 32'hFFFF_FFFF, 32'h0, outcome(ST_OK, 0, 1, 1, 0, 0)));
      plan.push_back(typed_row(OP_FIND, 32'h0, 32'h0,
                               outcome(ST_OK, 32'hFFFF_FFFF, 0, 0, 0, 0)));
      plan.push_back(typed_row(OP_ADD, 32'h0, 32'h5A5A_A5A5, outcome(ST_OK, 0, 0, 2, 0, 0)));
      plan.push_back(typed_row(OP_DELETE, 32'h0, 32'h0, outcome(ST_OK, 0, 0, 3, 0, 0)));
      plan.push_back(typed_row(OP_ADD, 32'h8000_0001, 32'h7FFF_FFFE,
                               outcome(ST_OK, 0, 0, 4, 0, 0)));
      // fill the remaining slots, then overflow the table
      for (i = 0; i < SLOTS - 2; i++)
         plan.push_back(item_row(OP_ADD, 32'h100 + i, 32'h0F0F_0000 | i));
      plan.push_back(typed_row(OP_ADD, 32'hDEAD_BEEF, 32'h1, outcome(ST_FULL, 0, 0, 0, 0, 0)));
      // zero write limit: every add or delete moves, even a miss
      plan.push_back(csr_row(0, -1));
      plan.push_back(item_row(OP_ADD, 32'hFFFF_FFFF, 32'h1));
      plan.push_back(item_row(OP_DELETE, 32'h1234, 32'h0));
      // zero block count: the move lands on block zero, a full add keeps it
      plan.push_back(csr_row(-1, 0));
      plan.push_back(item_row(OP_ADD, 32'hDEAD_BEEF, 32'h2));
      // block count beyond the 8-bit block index
      plan.push_back(csr_row(-1, 300));
      plan.push_back(item_row(OP_DELETE, 32'h8000_0001, 32'h0));
      plan.push_back(csr_row(65535, 256));
      plan.push_back(item_row(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000));

      foreach (plan[j]) begin
         if (plan[j].is_csr)
            apply_settings(plan[j].set_limit, plan[j].set_count);
         else
            send_item(plan[j].op, plan[j].key, plan[j].value, plan[j].typed, plan[j].want);
      end

      // Random phases: each with its own settings, idling and key pool.
      // Keys come mostly from a small pool so adds collide, the table fills
      // and deletes hit; the rest are fresh keys.
      for (ph = 0; ph < PHASES; ph++) begin
         apply_settings(phase_limit[ph], phase_count[ph]);
         send_idle_pct = phase_send_idle[ph];
         sink_idle_pct = phase_sink_idle[ph];
         for (i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom();
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            op = (pick < 40) ? OP_ADD : (pick < 68) ? OP_DELETE : (pick < 93) ? OP_FIND : OP_NONE;
            k  = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(KEY_POOL - 1)];
            send_item(op, k, $urandom(), 1'b0, '0);
         end
      end

      // drop valid, drain what is owed, then let the block settle
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d add, %0d delete, %0d find) over %0d register settings",
               n_items, n_add, n_del, n_find, n_settings);
      $display("Saw %0d block moves, %0d table-full replies, %0d response beats checked",
               n_moves, n_full, beats_seen);
      if (errors == 0 && expected_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
